/* design/fcx_pkg.sv */
// ----------------------------------------------------------------------------
// fcx_pkg
// Shared types and constants of the flow cache exporter.
// ----------------------------------------------------------------------------
package fcx_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] timestamp_ms;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] ip_length;
    logic [7:0]  type_of_service;
  } in_word_t;

  typedef struct packed {
    logic [31:0] export_sequence;
    logic [31:0] flow_src_ip;
    logic [31:0] flow_dst_ip;
    logic [31:0] port_pair;
    logic [7:0]  flow_protocol;
    logic [7:0]  flow_tos;
    logic [7:0]  flow_flags;
    logic [31:0] packet_count;
    logic [31:0] octet_count;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] pkts;
    logic [31:0] octs;
    logic [31:0] first;
    logic [31:0] last;
    logic [7:0]  tos;
    logic [7:0]  flags;
  } entry_t;

  localparam int EntryWidth = $bits(entry_t);

  localparam logic [1:0] FN_NONIP  = 2'd0;
  localparam logic [1:0] FN_IPV4   = 2'd1;
  localparam logic [1:0] FN_FLUSH  = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [7:0] TH_FIN = 8'h01;
  localparam logic [7:0] TH_RST = 8'h04;

  localparam logic [1:0] REG_ACTIVE   = 2'd0;
  localparam logic [1:0] REG_INACTIVE = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  typedef struct packed {
    logic latch;
    logic pos_clr;
    logic pos_inc;
    logic emit;
    logic drop;
    logic write_upd;
    logic write_ins;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       pos_lt_occ;
    logic       occ_zero;
    logic       exp_act;
    logic       exp_inact;
    logic       key_eq;
    logic       need_evict;
    logic       fin;
    logic       out_free;
  } sts_t;

endpackage

/* design/flow_cache_exporter.sv */
// ----------------------------------------------------------------------------
// flow_cache_exporter
// Flow cache keyed on the 5-tuple with active, idle, eviction, FIN/RST and flush export.
// ----------------------------------------------------------------------------
//  channel  signals                               word
//  in       in_valid / in_ready / in_word         parsed packet header
//  out      out_valid / out_ready / out_word      exported flow record
//  cfg      cfg_write / cfg_index / cfg_data      timer and limit registers
//
//  A packet walks the stored flows in the active and idle passes, and an IPv4
//  packet also in the match pass (RAM read, then check, per flow), plus an
//  eviction or FIN export where needed. Flush reads and exports each flow.
//  Reset is synchronous; the cache comes up empty with no clearing pass.
//  A stalled output holds the sequencer at the next export.
// ----------------------------------------------------------------------------
module flow_cache_exporter #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcx_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output fcx_pkg::out_word_t out_word,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import fcx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcx_datapath #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* design/fcx_ram.sv */
// ----------------------------------------------------------------------------
// fcx_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fcx_ctrl.sv */
// ----------------------------------------------------------------------------
// fcx_ctrl
// Sequencer: flush, active and idle scans, match, update, evict, insert, FIN export.
// ----------------------------------------------------------------------------
module fcx_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  fcx_pkg::sts_t sts,
  output fcx_pkg::cmd_t cmd
);
  import fcx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_RD, S_CHK, S_UPD, S_INS, S_DONE} state_t;
  typedef enum logic [2:0] {PH_FLUSH, PH_ACT, PH_INACT, PH_MATCH, PH_EVICT, PH_FIN} phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.pos_clr = 1'b1;
        case (sts.func)
          FN_FLUSH: begin
            phase_next = PH_FLUSH;
            state_next = S_RD;
          end
          FN_NONIP, FN_IPV4: begin
            phase_next = PH_ACT;
            state_next = S_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD: begin
        unique case (phase)
          PH_FLUSH: state_next = sts.occ_zero ? S_DONE : S_CHK;
          PH_ACT: begin
            if (sts.pos_lt_occ) begin
              state_next = S_CHK;
            end else begin
              phase_next  = PH_INACT;
              cmd.pos_clr = 1'b1;
            end
          end
          PH_INACT: begin
            if (sts.pos_lt_occ) begin
              state_next = S_CHK;
            end else if (sts.func == FN_IPV4) begin
              phase_next  = PH_MATCH;
              cmd.pos_clr = 1'b1;
            end else begin
              state_next = S_DONE;
            end
          end
          PH_MATCH: begin
            if (sts.pos_lt_occ) begin
              state_next = S_CHK;
            end else if (sts.need_evict) begin
              phase_next  = PH_EVICT;
              cmd.pos_clr = 1'b1;
            end else begin
              state_next = S_INS;
            end
          end
          default: state_next = S_CHK;
        endcase
      end
      S_CHK: begin
        unique case (phase)
          PH_ACT, PH_INACT: begin
            if ((phase == PH_ACT) ? sts.exp_act : sts.exp_inact) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.drop   = 1'b1;
                state_next = S_RD;
              end
            end else begin
              cmd.pos_inc = 1'b1;
              state_next  = S_RD;
            end
          end
          PH_MATCH: begin
            if (sts.key_eq) begin
              state_next = S_UPD;
            end else begin
              cmd.pos_inc = 1'b1;
              state_next  = S_RD;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.drop = 1'b1;
              unique case (phase)
                PH_EVICT: state_next = S_INS;
                PH_FIN:   state_next = S_DONE;
                default:  state_next = S_RD;
              endcase
            end
          end
        endcase
      end
      S_UPD, S_INS: begin
        cmd.write_upd = (state == S_UPD);
        cmd.write_ins = (state == S_INS);
        if (sts.fin) begin
          phase_next = PH_FIN;
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FLUSH;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

/* design/fcx_datapath.sv */
// ----------------------------------------------------------------------------
// fcx_datapath
// Flow RAM, insertion order list, timers, key compare and export buffering.
// ----------------------------------------------------------------------------
module fcx_datapath #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  fcx_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output fcx_pkg::out_word_t out_word,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  fcx_pkg::cmd_t     cmd,
  output fcx_pkg::sts_t     sts
);
  import fcx_pkg::*;

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [6:0] NMAX = 7'(CACHE_ENTRIES);

  logic [31:0] active_timeout, inactive_timeout;
  logic [5:0]  cache_limit;

  logic [IW-1:0] order [CACHE_ENTRIES];
  logic [CW-1:0] pos, occ;
  logic [31:0]   origin, up;
  logic          origin_seen;
  logic [1:0]    func;
  key_t          key;
  logic [7:0]    flags, tos;
  logic [15:0]   len;
  logic [31:0]   seq;
  out_word_t     hold;
  logic          hold_have;

  entry_t        rd, wr;
  logic [IW-1:0] rslot, waddr;
  logic          we;
  logic [EntryWidth-1:0] rdata;

  // input key build
  key_t        key_in;
  logic [7:0]  flags_in;
  logic [31:0] base;
  always_comb begin
    key_in.src   = in_word.src_ip;
    key_in.dst   = in_word.dst_ip;
    key_in.proto = in_word.protocol;
    key_in.sport = '0;
    key_in.dport = '0;
    flags_in     = '0;
    if (in_word.protocol == PROTO_TCP || in_word.protocol == PROTO_UDP) begin
      key_in.sport = in_word.port_a;
      key_in.dport = in_word.port_b;
    end else if (in_word.protocol == PROTO_ICMP) begin
      key_in.dport = {in_word.port_a[7:0], in_word.port_b[7:0]};
    end
    if (in_word.protocol == PROTO_TCP) begin
      flags_in = in_word.tcp_flag_bits;
    end
    base = origin_seen ? origin : in_word.timestamp_ms;
  end

  assign rslot = order[pos[IW-1:0]];
  assign rd    = entry_t'(rdata);

  fcx_ram #(.WIDTH(EntryWidth), .DEPTH(CACHE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (EntryWidth'(wr)),
    .raddr (rslot),
    .rdata (rdata)
  );

  always_comb begin
    we    = cmd.write_upd | cmd.write_ins;
    waddr = cmd.write_ins ? order[occ[IW-1:0]] : rslot;
    wr    = rd;
    if (cmd.write_ins) begin
      wr.key   = key;
      wr.pkts  = 32'd1;
      wr.octs  = {16'd0, len};
      wr.first = up;
      wr.tos   = tos;
      wr.flags = flags;
    end else begin
      wr.pkts  = rd.pkts + 32'd1;
      wr.octs  = rd.octs + {16'd0, len};
      wr.flags = rd.flags | flags;
    end
    wr.last = up;
  end

  logic [6:0] lim;
  logic       out_free;
  always_comb begin
    if (cache_limit == 6'd0) begin
      lim = 7'd1;
    end else if ({1'b0, cache_limit} > NMAX) begin
      lim = NMAX;
    end else begin
      lim = {1'b0, cache_limit};
    end
    out_free       = !out_valid || out_ready;
    sts.func       = func;
    sts.pos_lt_occ = pos < occ;
    sts.occ_zero   = occ == '0;
    sts.exp_act    = (rd.last - rd.first) > active_timeout;
    sts.exp_inact  = (up - rd.last) > inactive_timeout;
    sts.key_eq     = rd.key == key;
    sts.need_evict = (7'(occ) >= lim) && (occ != '0);
    sts.fin        = (flags & (TH_FIN | TH_RST)) != 8'd0;
    sts.out_free   = out_free;
  end

  out_word_t ex;
  always_comb begin
    ex.export_sequence = seq + 32'd1;
    ex.flow_src_ip     = rd.key.src;
    ex.flow_dst_ip     = rd.key.dst;
    ex.port_pair       = {rd.key.sport, rd.key.dport};
    ex.flow_protocol   = rd.key.proto;
    ex.flow_tos        = rd.tos;
    ex.flow_flags      = rd.flags;
    ex.packet_count    = rd.pkts;
    ex.octet_count     = rd.octs;
    ex.first_ms        = rd.first;
    ex.last_ms         = rd.last;
    ex.last_of_run     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_timeout   <= 32'd60000;
      inactive_timeout <= 32'd10000;
      cache_limit      <= 6'd32;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        order[i] <= IW'(i);
      end
      pos         <= '0;
      occ         <= '0;
      origin      <= '0;
      origin_seen <= 1'b0;
      seq         <= '0;
      hold_have   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ACTIVE:   active_timeout   <= cfg_data;
          REG_INACTIVE: inactive_timeout <= cfg_data;
          REG_LIMIT:    cache_limit      <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        func  <= in_word.func;
        key   <= key_in;
        flags <= flags_in;
        tos   <= in_word.type_of_service;
        len   <= in_word.ip_length;
        up    <= in_word.timestamp_ms - base;
        if (!origin_seen && (in_word.func == FN_NONIP || in_word.func == FN_IPV4)) begin
          origin      <= in_word.timestamp_ms;
          origin_seen <= 1'b1;
        end
      end
      if (cmd.pos_clr) pos <= '0;
      if (cmd.pos_inc) pos <= pos + 1'b1;
      if (cmd.drop) begin
        // close the gap and park the freed slot just past the live part
        for (int i = 0; i < CACHE_ENTRIES - 1; i++) begin
          if (CW'(i) >= pos && CW'(i + 1) < occ) order[i] <= order[i + 1];
        end
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (CW'(i + 1) == occ) order[i] <= rslot;
        end
        occ <= occ - 1'b1;
      end
      if (cmd.write_ins) begin
        pos <= occ;
        occ <= occ + 1'b1;
      end
      if ((cmd.emit || cmd.finish) && hold_have) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        if (hold_have) begin
          out_word <= hold;
        end
        hold      <= ex;
        hold_have <= 1'b1;
        seq       <= seq + 32'd1;
      end
      if (cmd.finish && hold_have) begin
        out_word  <= out_word_t'({hold[$bits(out_word_t)-1:1], 1'b1});
        hold_have <= 1'b0;
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    7'(occ) <= NMAX) else $error("occupancy beyond cache size");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || (cmd.finish && hold_have)) |-> out_free)
    else $error("output register overwritten");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write_ins |-> (7'(occ) < NMAX)) else $error("insert into full cache");
  a_drop_live: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (pos < occ)) else $error("drop outside live entries");

endmodule
